>>> rtl/mtsb_pkg.sv
// Types and constants shared by the tray slot buffer modules.
package mtsb_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAYS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'b1;

    localparam logic [3:0] TRAYS_RESET = 4'd8;
    localparam logic [5:0] SLOTS_RESET = 6'd32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_FULL     = 3'd1;
    localparam logic [2:0] STATUS_EMPTY    = 3'd2;
    localparam logic [2:0] STATUS_BAD_TRAY = 3'd3;
    localparam logic [2:0] STATUS_ZERO_QTY = 3'd4;

    typedef struct packed {
        logic        op;
        logic [2:0]  tray;
        logic [15:0] rec_id;
        logic [7:0]  kind;
        logic [15:0] quantity;
        logic [3:0]  delay;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] out_id;
        logic [7:0]  out_kind;
        logic [15:0] out_quantity;
        logic [3:0]  out_delay;
        logic [31:0] total_inserted;
    } out_t;

    typedef struct packed {
        logic [15:0] rec_id;
        logic [7:0]  kind;
        logic [15:0] quantity;
        logic [3:0]  delay;
    } rec_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_FIND,
        CTRL_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } dp_cmd_t;

endpackage

>>> rtl/mtsb_ctrl.sv
// Controller state machine: input and output handshakes and datapath sequencing.
module mtsb_ctrl
    import mtsb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                in_stall = 1'b0;
            end
            CTRL_FIND:
            begin
                cmd.exec = 1'b1;
            end
            CTRL_DONE:
            begin
                in_stall     = !out_free;
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        cmd.load_in = in_valid && !in_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CTRL_FIND;
                end
            end
            CTRL_FIND:
            begin
                state_next = CTRL_DONE;
            end
            CTRL_DONE:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? CTRL_FIND : CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/mtsb_dp.sv
// Datapath: configuration, occupancy maps, slot search, record memory and result register.
module mtsb_dp
    import mtsb_pkg::*;
#(
    parameter int MAX_TRAYS = 8,
    parameter int MAX_SLOTS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    input  in_t                   in_data,
    output out_t                  out_data
);

    localparam int TRAY_W = (MAX_TRAYS > 1) ? $clog2(MAX_TRAYS) : 1;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DEPTH  = MAX_TRAYS * MAX_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [3:0]           trays_reg;
    logic [5:0]           slots_reg;
    logic [MAX_SLOTS-1:0] map_reg [MAX_TRAYS];
    logic [31:0]          count_reg;
    in_t                  in_reg;
    logic [2:0]           status_reg;
    logic [SLOT_W-1:0]    slot_reg;
    rec_t                 rdata_reg;
    out_t                 out_reg;
    rec_t                 mem [DEPTH];

    logic [TRAY_W-1:0]    tray_idx;
    logic                 tray_ok;
    logic [MAX_SLOTS-1:0] row;
    logic [MAX_SLOTS-1:0] act;
    logic [MAX_SLOTS-1:0] cand;
    logic [MAX_SLOTS-1:0] lowest;
    logic [SLOT_W-1:0]    enc;
    logic                 found;
    logic [2:0]           status;
    logic [ADDR_W-1:0]    addr;
    logic                 ins_ok;
    logic                 rem_ok;
    logic                 hit_ok;
    rec_t                 wrec;

    assign tray_idx = TRAY_W'(in_reg.tray);
    assign tray_ok  = (4'(in_reg.tray) < trays_reg) && (7'(in_reg.tray) < 7'(MAX_TRAYS));
    assign row      = tray_ok ? map_reg[tray_idx] : '0;

    always_comb
    begin
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            act[s] = 7'(s) < 7'(slots_reg);
        end
    end

    assign cand   = (in_reg.op == OP_REMOVE) ? (row & act) : (~row & act);
    assign lowest = cand & (~cand + MAX_SLOTS'(1));
    assign found  = |cand;

    always_comb
    begin
        enc = '0;
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            if (lowest[s])
            begin
                enc = enc | SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        if (!tray_ok)
        begin
            status = STATUS_BAD_TRAY;
        end
        else if (in_reg.op == OP_INSERT)
        begin
            if (in_reg.quantity == 16'd0)
            begin
                status = STATUS_ZERO_QTY;
            end
            else
            begin
                status = found ? STATUS_OK : STATUS_FULL;
            end
        end
        else
        begin
            status = found ? STATUS_OK : STATUS_EMPTY;
        end
    end

    assign ins_ok = cmd.exec && (status == STATUS_OK) && (in_reg.op == OP_INSERT);
    assign rem_ok = cmd.exec && (status == STATUS_OK) && (in_reg.op == OP_REMOVE);
    assign addr   = ADDR_W'(tray_idx) * ADDR_W'(MAX_SLOTS) + ADDR_W'(enc);
    assign hit_ok = status_reg == STATUS_OK;

    assign wrec.rec_id   = in_reg.rec_id;
    assign wrec.kind     = in_reg.kind;
    assign wrec.quantity = in_reg.quantity;
    assign wrec.delay    = in_reg.delay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trays_reg <= TRAYS_RESET;
            slots_reg <= SLOTS_RESET;
            count_reg <= '0;
            for (int t = 0; t < MAX_TRAYS; t++)
            begin
                map_reg[t] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TRAYS: trays_reg <= cfg_data[3:0];
                    CFG_SLOTS: slots_reg <= cfg_data;
                    default:   trays_reg <= trays_reg;
                endcase
            end
            if (ins_ok)
            begin
                map_reg[tray_idx] <= row | lowest;
                count_reg         <= count_reg + 32'd1;
            end
            else if (rem_ok)
            begin
                map_reg[tray_idx] <= row & ~lowest;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.exec)
        begin
            status_reg <= status;
            slot_reg   <= enc;
            rdata_reg  <= mem[addr];
        end
        if (ins_ok)
        begin
            mem[addr] <= wrec;
        end
        if (cmd.load_out)
        begin
            out_reg.status         <= status_reg;
            out_reg.slot           <= hit_ok ? 5'(slot_reg) : 5'd0;
            out_reg.total_inserted <= count_reg;
            if (hit_ok && (in_reg.op == OP_REMOVE))
            begin
                out_reg.out_id       <= rdata_reg.rec_id;
                out_reg.out_kind     <= rdata_reg.kind;
                out_reg.out_quantity <= rdata_reg.quantity;
                out_reg.out_delay    <= rdata_reg.delay;
            end
            else
            begin
                out_reg.out_id       <= '0;
                out_reg.out_kind     <= '0;
                out_reg.out_quantity <= '0;
                out_reg.out_delay    <= '0;
            end
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/multi_tray_slot_buffer.sv
// Top level of the tray slot buffer: controller and datapath.
//
// An input beat (in_valid, in_stall, in_data) carries one insert or remove
// request for one tray. Each accepted beat gives exactly one result beat
// (out_valid, out_stall, out_data) with a status, the slot touched, the
// removed record on a good remove, and the running insert count.
// A request is searched and then its result is registered: the lowest-slot
// search over the tray's occupancy map and the record memory access run in
// the cycle after the accepting edge, and the result register loads at the
// end of the done state once it is free. Input is refused during the search
// cycle, so a new beat is taken only after the previous one has been searched.
// The result register holds a finished beat while out_stall is high; one
// more request is then searched and waits, and in_stall rises until the
// result register frees.
// Reset clears the occupancy maps (all slots free), the insert count and the
// configuration (eight trays, 32 slots); the record memory is not cleared.
// Write configuration through cfg_we, cfg_index and cfg_data while idle.
module multi_tray_slot_buffer
    import mtsb_pkg::*;
#(
    parameter int MAX_TRAYS = 8,
    parameter int MAX_SLOTS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data
);

    dp_cmd_t cmd;

    mtsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mtsb_dp #(
        .MAX_TRAYS (MAX_TRAYS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data)
    );

endmodule
